@@ rtl/rounded_rect_hit_test_top_assert.svh @@
// Assertion macros used by the hit-test top level.
`ifndef ROUNDED_RECT_HIT_TEST_TOP_ASSERT_SVH
`define ROUNDED_RECT_HIT_TEST_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RRHT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define RRHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/rrht_pkg.sv @@
// Shared constants and types of the rounded-rectangle hit test.
package rrht_pkg;

	localparam int COORD_BITS = 16;
	localparam int BOX_BITS   = 15;
	localparam int RAD_BITS   = 16;
	localparam int CFG_BITS   = 32;
	localparam int CFG_IDX_BITS = 3;
	localparam int CMP_BITS   = ((COORD_BITS > RAD_BITS) ? COORD_BITS : RAD_BITS) + 2;
	localparam int NUM_CORNERS = 4;
	localparam int NSTG       = 6;
	localparam int PROD_BITS  = 2 * RAD_BITS;
	localparam int SQ_BITS    = 2 * PROD_BITS;
	localparam int CUBE_BITS  = 3 * PROD_BITS;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_TOP_LEFT     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TOP_RIGHT    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOTTOM_LEFT  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOTTOM_RIGHT = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_KIND  = 3'd4;

	// corner shapes
	localparam logic [1:0] KIND_ELLIPSE  = 2'd0;
	localparam logic [1:0] KIND_SQUIRCLE = 2'd1;
	localparam logic [1:0] KIND_CUT      = 2'd2;

	// per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} rrht_en_t;

endpackage

@@ rtl/rrht_ctrl.sv @@
// Valid tracking and bubble-collapsing stall control of the pipeline.
module rrht_ctrl import rrht_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     out_ready,
	output logic     in_ready,
	output logic     out_valid,
	output rrht_en_t en
);

	logic [NSTG:1] v_q;
	logic [NSTG:1] ld;
	logic [NSTG:0] vin;

	// a stage loads when empty or when the next one moves
	always_comb begin
		ld[NSTG] = !v_q[NSTG] || out_ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			ld[k] = !v_q[k] || ld[k+1];
		end
		vin = {v_q, in_valid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (ld[k]) begin
					v_q[k] <= vin[k-1];
				end
			end
		end
	end

	assign in_ready  = ld[1];
	assign out_valid = v_q[NSTG];
	assign en = '{s1: ld[1], s2: ld[2], s3: ld[3], s4: ld[4], s5: ld[5], s6: ld[6]};

endmodule

@@ rtl/rrht_corner.sv @@
// Division-free corner test, stages two to six.
module rrht_corner import rrht_pkg::*; (
	input  logic                clk,
	input  rrht_en_t            en,
	input  logic [1:0]          kind,
	input  logic [RAD_BITS-1:0] rx,
	input  logic [RAD_BITS-1:0] ry,
	input  logic                act_s1,
	input  logic [RAD_BITS-1:0] dx_s1,
	input  logic [RAD_BITS-1:0] dy_s1,
	output logic                outside_s6
);

	logic                 act_s2, act_s3, act_s4, act_s5;
	logic [PROD_BITS-1:0] a_s2, b_s2, c_s2, a_s3, b_s3, c_s3;
	logic [SQ_BITS-1:0]   a2_s3, b2_s3, c2_s3;
	logic [SQ_BITS-1:0]   alo_s4, ahi_s4, blo_s4, bhi_s4, clo_s4, chi_s4;
	logic                 ell_s4, lin_s4, ell_s5, lin_s5;
	logic [CUBE_BITS-1:0] a3_s5, b3_s5, c3_s5;
	logic [CUBE_BITS:0]   cube_sum;
	logic                 sel_out;

	// a = dx*ry, b = dy*rx, c = rx*ry
	always_ff @(posedge clk) begin
		if (en.s2) begin
			act_s2 <= act_s1;
			a_s2   <= dx_s1 * ry;
			b_s2   <= dy_s1 * rx;
			c_s2   <= rx * ry;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			act_s3 <= act_s2;
			a_s3   <= a_s2;
			b_s3   <= b_s2;
			c_s3   <= c_s2;
			a2_s3  <= a_s2 * a_s2;
			b2_s3  <= b_s2 * b_s2;
			c2_s3  <= c_s2 * c_s2;
		end
	end

	// cube partial products, ellipse and cut compares
	always_ff @(posedge clk) begin
		if (en.s4) begin
			act_s4 <= act_s3;
			alo_s4 <= a2_s3[PROD_BITS-1:0] * a_s3;
			ahi_s4 <= a2_s3[SQ_BITS-1:PROD_BITS] * a_s3;
			blo_s4 <= b2_s3[PROD_BITS-1:0] * b_s3;
			bhi_s4 <= b2_s3[SQ_BITS-1:PROD_BITS] * b_s3;
			clo_s4 <= c2_s3[PROD_BITS-1:0] * c_s3;
			chi_s4 <= c2_s3[SQ_BITS-1:PROD_BITS] * c_s3;
			ell_s4 <= ({1'b0, a2_s3} + {1'b0, b2_s3}) > {1'b0, c2_s3};
			lin_s4 <= ({1'b0, a_s3} + {1'b0, b_s3}) > {1'b0, c_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			act_s5 <= act_s4;
			ell_s5 <= ell_s4;
			lin_s5 <= lin_s4;
			a3_s5  <= CUBE_BITS'(alo_s4) + {ahi_s4, {PROD_BITS{1'b0}}};
			b3_s5  <= CUBE_BITS'(blo_s4) + {bhi_s4, {PROD_BITS{1'b0}}};
			c3_s5  <= CUBE_BITS'(clo_s4) + {chi_s4, {PROD_BITS{1'b0}}};
		end
	end

	always_comb begin
		cube_sum = {1'b0, a3_s5} + {1'b0, b3_s5};
		case (kind)
			KIND_SQUIRCLE: sel_out = cube_sum > {1'b0, c3_s5};
			KIND_CUT:      sel_out = lin_s5;
			default:       sel_out = ell_s5;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			outside_s6 <= act_s5 && sel_out;
		end
	end

endmodule

@@ rtl/rounded_rect_hit_test_top.sv @@
// Throughput: one request per cycle; stalls hold only the stages that are full.
// Longest path: a 32x32 multiply in the square and cube stages or a 97-bit add and compare (squircle test).
// Reset: arst_n clears all valid bits and the five configuration registers to zero.
// Radii and corner kind are read live, so write them only while the pipe is empty.
// Top level of the rounded-rectangle hit test.
module rounded_rect_hit_test_top import rrht_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [BOX_BITS-1:0]     box_width,
	input  logic [BOX_BITS-1:0]     box_height,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    inside_res
);

	`include "rounded_rect_hit_test_top_assert.svh"

	// Configuration registers: one word per corner plus the shape code.
	logic [CFG_BITS-1:0] radii_q [NUM_CORNERS];
	logic [1:0]          kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CORNERS; k++) begin
				radii_q[k] <= '0;
			end
			kind_q <= KIND_ELLIPSE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TOP_LEFT:     radii_q[0] <= cfg_data;
				REG_TOP_RIGHT:    radii_q[1] <= cfg_data;
				REG_BOTTOM_LEFT:  radii_q[2] <= cfg_data;
				REG_BOTTOM_RIGHT: radii_q[3] <= cfg_data;
				REG_CORNER_KIND:  kind_q     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Stall control.
	rrht_en_t en;

	rrht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.en        (en)
	);

	// Stage 1 front end: box check and per-corner distances.
	// Corner 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right:
	// bit 0 of the number picks the right side, bit 1 the bottom side.
	logic signed [CMP_BITS-1:0] xs, ys, ws, hs;
	logic signed [CMP_BITS-1:0] rxe, rye, xedge, yedge, dxe, dye;
	logic                       xok, yok;
	logic                       inbox;
	logic [NUM_CORNERS-1:0]     act;
	logic [RAD_BITS-1:0]        dx [NUM_CORNERS];
	logic [RAD_BITS-1:0]        dy [NUM_CORNERS];

	always_comb begin
		xs = {{(CMP_BITS-COORD_BITS){point_x[COORD_BITS-1]}}, point_x};
		ys = {{(CMP_BITS-COORD_BITS){point_y[COORD_BITS-1]}}, point_y};
		ws = CMP_BITS'(box_width);
		hs = CMP_BITS'(box_height);
		inbox = !(xs < 0 || ys < 0 || xs > ws || ys > hs);
		for (int k = 0; k < NUM_CORNERS; k++) begin
			rxe = CMP_BITS'(radii_q[k][RAD_BITS-1:0]);
			rye = CMP_BITS'(radii_q[k][CFG_BITS-1:RAD_BITS]);
			xedge = ws - rxe;
			yedge = hs - rye;
			if (k[0]) begin
				xok = xs > xedge;
				dxe = xs - xedge;
			end else begin
				xok = xs < rxe;
				dxe = rxe - xs;
			end
			if (k[1]) begin
				yok = ys > yedge;
				dye = ys - yedge;
			end else begin
				yok = ys < rye;
				dye = rye - ys;
			end
			// distances stay within the radius whenever the corner is active and the point lies in the box
			act[k] = (rxe != 0) && xok && yok;
			dx[k]  = dxe[RAD_BITS-1:0];
			dy[k]  = dye[RAD_BITS-1:0];
		end
	end

	logic [NUM_CORNERS-1:0] act_s1;
	logic [RAD_BITS-1:0]    dx_s1 [NUM_CORNERS];
	logic [RAD_BITS-1:0]    dy_s1 [NUM_CORNERS];
	logic                   inbox_s1, inbox_s2, inbox_s3, inbox_s4, inbox_s5, inbox_s6;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			act_s1   <= act;
			dx_s1    <= dx;
			dy_s1    <= dy;
			inbox_s1 <= inbox;
		end
	end

	// Box flag rides alongside the corner datapath.
	always_ff @(posedge clk) begin
		if (en.s2) inbox_s2 <= inbox_s1;
		if (en.s3) inbox_s3 <= inbox_s2;
		if (en.s4) inbox_s4 <= inbox_s3;
		if (en.s5) inbox_s5 <= inbox_s4;
		if (en.s6) inbox_s6 <= inbox_s5;
	end

	// Four corner units; any one failing marks the point outside.
	logic [NUM_CORNERS-1:0] outside_s6;

	for (genvar g = 0; g < NUM_CORNERS; g++) begin : g_corner
		rrht_corner u_corner (
			.clk        (clk),
			.en         (en),
			.kind       (kind_q),
			.rx         (radii_q[g][RAD_BITS-1:0]),
			.ry         (radii_q[g][CFG_BITS-1:RAD_BITS]),
			.act_s1     (act_s1[g]),
			.dx_s1      (dx_s1[g]),
			.dy_s1      (dy_s1[g]),
			.outside_s6 (outside_s6[g])
		);
	end

	assign inside_res = inbox_s6 && !(|outside_s6);

	// An empty output stage means nothing can block the input.
	`RRHT_ASSERT_NOW(a_drain_ready, !out_valid, in_ready, "input blocked with empty output stage")
	// A held stage 1 must not drop its request.
	`RRHT_ASSERT_NEXT(a_s1_hold, u_ctrl.v_q[1] && !en.s1, u_ctrl.v_q[1], "stage 1 request lost")
	// An accepted request lands in stage 1.
	`RRHT_ASSERT_NEXT(a_s1_load, in_valid && in_ready, u_ctrl.v_q[1], "accepted request missing")

endmodule
